// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cffc_pkg.sv =====
// Package with types and constants of the capacity-limited first-fit colouring block.
`default_nettype none
package cffc_pkg;

  localparam int unsigned NV      = 128;               // vertices
  localparam int unsigned VW      = $clog2(NV);        // vertex number width
  localparam int unsigned NB      = 64;                // bins
  localparam int unsigned BW      = $clog2(NB);        // bin number width
  localparam int unsigned SEATS   = 4;                 // seats per bin
  localparam int unsigned SW      = 2;                 // seat field width
  localparam int unsigned FW      = $clog2(SEATS + 1); // fill count width
  localparam int unsigned TL_W    = 7;                 // table limit register width
  localparam int unsigned TL_RST  = 64;                // table limit after reset

  typedef enum logic [1:0] {
    ST_CONFLICT   = 2'd0,
    ST_PLACED     = 2'd1,
    ST_IMPOSSIBLE = 2'd2
  } status_e;

  typedef enum logic {
    CMD_CONFLICT = 1'b0,
    CMD_PLACE    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONF_A,
    S_CONF_B,
    S_PLACE_ROW,
    S_PLACE_SRCH
  } state_e;

  typedef struct packed {
    logic [FW-1:0]            fill;
    logic [SEATS-1:0][VW-1:0] member;
  } bin_row_t;

  typedef struct packed {
    logic          re;
    logic          we;
    logic [VW-1:0] raddr;
    logic [VW-1:0] waddr;
    logic [NV-1:0] wdata;
  } crow_req_t;

  typedef struct packed {
    logic          re;
    logic          we;
    logic [BW-1:0] raddr;
    logic [BW-1:0] waddr;
    bin_row_t      wdata;
  } bin_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/cffc_conflict_mem.sv =====
// Conflict matrix memory, one row per vertex, with per-row valid bits for reset.
`default_nettype none
module cffc_conflict_mem
  import cffc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  crow_req_t      req_i,
  output logic [NV-1:0]  rdata_o
);

  logic [NV-1:0] mem_q [NV];
  logic [NV-1:0] valid_q;
  logic [NV-1:0] rd_q;
  logic          rd_valid_q;

  // A row never written reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/core/cffc_bin_mem.sv =====
// Bin memory: fill count and seated members of each bin, per-bin valid bits for reset.
`default_nettype none
module cffc_bin_mem
  import cffc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  bin_req_t  req_i,
  output bin_row_t  rdata_o
);

  bin_row_t      mem_q [NB];
  logic [NB-1:0] valid_q;
  bin_row_t      rd_q;
  logic          rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // An unwritten bin reads with a fill of zero; its members are then never looked at.
  always_comb begin
    rdata_o = rd_q;
    if (!rd_valid_q) begin
      rdata_o.fill = '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/capacity_first_fit_coloring.sv =====
// Top level of the capacity-limited first-fit colouring block.
// A conflict transaction keeps busy high through S_CONF_A and S_CONF_B; its result strobes
// as busy falls. A placement keeps busy high in S_PLACE_ROW and, unless the table
// limit is zero, in S_PLACE_SRCH, examining 1 to 64 bins, one per cycle, and strobes
// as busy falls; a placement refused after an earlier failure strobes in the cycle after it.
// Reset clears conflicts, bin fills and the failure flag at once and sets table_limit to 64.
`default_nettype none
module capacity_first_fit_coloring
  import cffc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            cmd_i,
  input  wire logic [VW-1:0]   guest_a_i,
  input  wire logic [VW-1:0]   guest_b_i,
  input  wire logic            table_limit_we_i,
  input  wire logic [TL_W-1:0] table_limit_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [BW-1:0]        table_res_o,
  output logic [SW-1:0]        seat_o
);

`include "assert_macros.svh"

  // Sequencer state and the transaction being worked on.
  state_e          state_q, state_d;
  logic [VW-1:0]   a_q, a_d;
  logic [VW-1:0]   b_q, b_d;
  logic [BW-1:0]   m_q, m_d;
  logic            failed_q, failed_d;
  logic [TL_W-1:0] table_limit_q;

  // Result registers; the strobe lasts exactly one cycle.
  logic            done_q, done_d;
  status_e         status_q, status_d;
  logic [BW-1:0]   table_q, table_d;
  logic [SW-1:0]   seat_q, seat_d;

  crow_req_t       crow_req;
  logic [NV-1:0]   crow_rd;
  bin_req_t        bin_req;
  bin_row_t        bin_rd;

  logic [TL_W-1:0]  limit;
  logic [SEATS-1:0] seat_hit;
  logic             bin_fits;
  logic             last_bin;
  logic             accept;

  cffc_conflict_mem u_conflict_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (crow_req),
    .rdata_o (crow_rd)
  );

  cffc_bin_mem u_bin_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bin_req),
    .rdata_o (bin_rd)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Bins above the number available are not searched.
  assign limit = (table_limit_q > TL_W'(NB)) ? TL_W'(NB) : table_limit_q;

  // A bin takes the vertex when it has a free seat and none of its seated members
  // conflicts with it. The vertex's conflict row stays in the memory's read
  // register for the whole search, since no other row is read meanwhile.
  always_comb begin
    for (int k = 0; k < SEATS; k++) begin
      seat_hit[k] = (FW'(k) < bin_rd.fill) && crow_rd[bin_rd.member[k]];
    end
    bin_fits = (bin_rd.fill < FW'(SEATS)) && (seat_hit == '0);
  end

  assign last_bin = (TL_W'(m_q) + TL_W'(1)) >= limit;

  always_comb begin
    state_d  = state_q;
    a_d      = a_q;
    b_d      = b_q;
    m_d      = m_q;
    failed_d = failed_q;
    done_d   = 1'b0;
    status_d = status_q;
    table_d  = table_q;
    seat_d   = seat_q;

    crow_req       = '0;
    crow_req.raddr = a_q;
    crow_req.waddr = a_q;
    bin_req        = '0;
    bin_req.raddr  = m_q + BW'(1);
    bin_req.waddr  = m_q;
    bin_req.wdata  = bin_rd;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          a_d            = guest_a_i;
          b_d            = guest_b_i;
          crow_req.raddr = guest_a_i;
          if (cmd_e'(cmd_i) == CMD_CONFLICT) begin
            crow_req.re = 1'b1;
            state_d     = S_CONF_A;
          end else if (failed_q) begin
            // Once a placement has failed every later one is refused.
            done_d   = 1'b1;
            status_d = ST_IMPOSSIBLE;
            table_d  = '0;
            seat_d   = '0;
          end else begin
            crow_req.re = 1'b1;
            state_d     = S_PLACE_ROW;
          end
        end
      end

      S_CONF_A: begin
        // Row a arrives: set bit b in it and fetch row b. When both vertices are the
        // same, both writes carry the same word, so the stale read of row b is harmless.
        crow_req.we    = 1'b1;
        crow_req.waddr = a_q;
        crow_req.wdata = crow_rd | (NV'(1) << b_q);
        crow_req.re    = 1'b1;
        crow_req.raddr = b_q;
        state_d        = S_CONF_B;
      end

      S_CONF_B: begin
        crow_req.we    = 1'b1;
        crow_req.waddr = b_q;
        crow_req.wdata = crow_rd | (NV'(1) << a_q);
        done_d         = 1'b1;
        status_d       = ST_CONFLICT;
        table_d        = '0;
        seat_d         = '0;
        state_d        = S_IDLE;
      end

      S_PLACE_ROW: begin
        m_d = '0;
        if (limit == '0) begin
          failed_d = 1'b1;
          done_d   = 1'b1;
          status_d = ST_IMPOSSIBLE;
          table_d  = '0;
          seat_d   = '0;
          state_d  = S_IDLE;
        end else begin
          bin_req.re    = 1'b1;
          bin_req.raddr = '0;
          state_d       = S_PLACE_SRCH;
        end
      end

      S_PLACE_SRCH: begin
        if (bin_fits) begin
          bin_req.we                                 = 1'b1;
          bin_req.wdata.member[bin_rd.fill[SW-1:0]]  = a_q;
          bin_req.wdata.fill                         = bin_rd.fill + FW'(1);
          done_d   = 1'b1;
          status_d = ST_PLACED;
          table_d  = m_q;
          seat_d   = bin_rd.fill[SW-1:0];
          state_d  = S_IDLE;
        end else if (last_bin) begin
          failed_d = 1'b1;
          done_d   = 1'b1;
          status_d = ST_IMPOSSIBLE;
          table_d  = '0;
          seat_d   = '0;
          state_d  = S_IDLE;
        end else begin
          bin_req.re = 1'b1;
          m_d        = m_q + BW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      failed_q      <= 1'b0;
      done_q        <= 1'b0;
      table_limit_q <= TL_W'(TL_RST);
    end else begin
      state_q  <= state_d;
      failed_q <= failed_d;
      done_q   <= done_d;
      if (table_limit_we_i) begin
        table_limit_q <= table_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    m_q      <= m_d;
    status_q <= status_d;
    table_q  <= table_d;
    seat_q   <= seat_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign table_res_o = table_q;
  assign seat_o      = seat_q;

  `ASSERT_CLKD(a_fail_sticky, clk_i, rst_ni, failed_q |=> failed_q, "failure flag cleared")
  `ASSERT_CLKD(a_srch_in_range, clk_i, rst_ni,
               (state_q == S_PLACE_SRCH) |-> (TL_W'(m_q) < limit),
               "bin search beyond table limit")
  `ASSERT_CLKD(a_bin_wr_room, clk_i, rst_ni,
               bin_req.we |-> (bin_rd.fill < FW'(SEATS)),
               "bin written while full")
  `ASSERT_CLK(a_result_zero, clk_i,
              (done_o && (status_o != ST_PLACED)) |-> ((table_res_o == '0) && (seat_o == '0)),
              "non-placement result carries a bin or seat")

endmodule
`default_nettype wire
